// ----- hdl/dcr_pkg.sv -----
// dcr_pkg: shared types and constants for the depth colour ramp.
// Request/result payload structs, request type codes, divider status.
// No dependencies.
package dcr_pkg;

    localparam int DEPTH_WIDTH_DEF = 32;
    localparam int FIELD_WIDTH     = 32;
    localparam int RAMP_BITS       = 9;
    localparam int CHAN_BITS       = 8;

    localparam logic REQ_SCAN  = 1'b0;
    localparam logic REQ_COLOR = 1'b1;

    typedef struct packed {
        logic                          req_type;
        logic                          first_item;
        logic signed [FIELD_WIDTH-1:0] depth_value;
    } dcr_req_t;

    typedef struct packed {
        logic [CHAN_BITS-1:0] red;
        logic [CHAN_BITS-1:0] green;
        logic [CHAN_BITS-1:0] blue;
        logic [RAMP_BITS-1:0] ramp_position;
        logic                 flat_range;
        logic                 no_data;
    } dcr_rsp_t;

    typedef struct packed {
        logic busy;
        logic done;
    } dcr_div_stat_t;

endpackage

// ----- hdl/depth_colour_ramp.sv -----
// depth_colour_ramp: top level, request FSM, colour map and result register.
// Depends on dcr_pkg, dcr_extremes, dcr_divider.
//
//   port group                   | dir | what
//   req_valid / req_ready / req  | in  | scan or colour request, dcr_req_t
//   rsp_valid / rsp_ready / rsp  | out | colour result, dcr_rsp_t
//
// Scan request: extremes updated at the accepting edge. Colour request: no division
// when there is no data, a flat range or a depth at or above the maximum; else the
// steps are numerator, overflow check (which may saturate the position), 9 quotient
// bits from the bit-serial divider, then the result register.
// One request in flight; the result register lets the next request in while
// the previous result waits on rsp_ready. Reset clears extremes and control.
module depth_colour_ramp #(
    parameter int DEPTH_WIDTH = dcr_pkg::DEPTH_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  dcr_pkg::dcr_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output dcr_pkg::dcr_rsp_t rsp
);
    import dcr_pkg::*;

    localparam int W = DEPTH_WIDTH;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic                rsp_valid_reg, rsp_valid_next;
    dcr_rsp_t            rsp_reg, rsp_next;

    logic signed [W-1:0] z, lowest, highest;
    logic                have_scan;
    logic                req_fire, scan_en, color_fire;
    logic [W:0]          diff;
    logic [W-1:0]        span;
    logic                diff_pos, flat, needs_div, div_start, rsp_load;

    logic [RAMP_BITS-1:0] pos_reg;
    logic                 flat_reg, nodata_reg;

    dcr_div_stat_t         div_stat;
    logic [RAMP_BITS-1:0]  quotient;

    generate
        if (W <= FIELD_WIDTH)
        begin : g_narrow
            assign z = req.depth_value[W-1:0];
        end
        else
        begin : g_wide
            assign z = W'(req.depth_value);
        end
    endgenerate

    assign req_ready  = state_reg == S_IDLE;
    assign req_fire   = req_valid && req_ready;
    assign scan_en    = req_fire && (req.req_type == REQ_SCAN);
    assign color_fire = req_fire && (req.req_type == REQ_COLOR);

    assign diff      = {highest[W-1], highest} - {z[W-1], z};
    assign span      = highest - lowest;
    assign diff_pos  = !diff[W] && (diff != '0);
    assign flat      = span == '0;
    assign needs_div = have_scan && !flat && diff_pos;
    assign div_start = color_fire && needs_div;
    assign rsp_load  = (state_reg == S_OUT) && (!rsp_valid_reg || rsp_ready);

    dcr_extremes #(.W(W)) u_extremes (
        .clk        (clk),
        .rst_n      (rst_n),
        .scan_en    (scan_en),
        .first_item (req.first_item),
        .depth      (z),
        .lowest     (lowest),
        .highest    (highest),
        .have_scan  (have_scan)
    );

    dcr_divider #(.W(W)) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (diff),
        .divisor  (span),
        .stat     (div_stat),
        .quotient (quotient)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (color_fire)
                    state_next = needs_div ? S_DIV : S_OUT;
            end
            S_DIV:
            begin
                if (div_stat.done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (rsp_load)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (color_fire)
        begin
            pos_reg    <= '0;
            flat_reg   <= have_scan && flat;
            nodata_reg <= !have_scan;
        end
        if (state_reg == S_DIV && div_stat.done)
            pos_reg <= quotient;
    end

    // blue-green for the lower half of the ramp, green-red for the upper half
    always_comb
    begin
        rsp_next               = '0;
        rsp_next.ramp_position = pos_reg;
        rsp_next.flat_range    = flat_reg;
        rsp_next.no_data       = nodata_reg;
        if (!nodata_reg)
        begin
            if (!pos_reg[RAMP_BITS-1])
            begin
                rsp_next.green = pos_reg[CHAN_BITS-1:0];
                rsp_next.blue  = ~pos_reg[CHAN_BITS-1:0];
            end
            else
            begin
                rsp_next.red   = pos_reg[CHAN_BITS-1:0];
                rsp_next.green = ~pos_reg[CHAN_BITS-1:0];
            end
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_load)
            rsp_valid_next = 1'b1;
        else if (rsp_ready)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_load)
            rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> state_reg == S_DIV)
        else $error("divider finished outside S_DIV");

    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_div_busy_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> state_reg == S_DIV)
        else $error("divider busy outside S_DIV");

    a_no_data_blank: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.no_data |-> rsp.ramp_position == '0 && !rsp.flat_range
            && rsp.blue == '0)
        else $error("no-data result not blank");

    a_red_blue_excl: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.red == '0 || rsp.blue == '0)
        else $error("red and blue both lit");

endmodule

// ----- hdl/dcr_extremes.sv -----
// dcr_extremes: running minimum / maximum of scanned depths.
// Depends on dcr_pkg (only for the default of W).
module dcr_extremes #(
    parameter int W = dcr_pkg::DEPTH_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                scan_en,
    input  logic                first_item,
    input  logic signed [W-1:0] depth,
    output logic signed [W-1:0] lowest,
    output logic signed [W-1:0] highest,
    output logic                have_scan
);
    localparam logic signed [W-1:0] POS_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] NEG_MIN = {1'b1, {(W-1){1'b0}}};

    logic signed [W-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic signed [W-1:0] lo_base, hi_base;
    logic                have_reg, have_next;

    always_comb
    begin
        lo_base   = first_item ? POS_MAX : lo_reg;
        hi_base   = first_item ? NEG_MIN : hi_reg;
        lo_next   = lo_reg;
        hi_next   = hi_reg;
        have_next = have_reg;
        if (scan_en)
        begin
            lo_next   = (depth < lo_base) ? depth : lo_base;
            hi_next   = (depth > hi_base) ? depth : hi_base;
            have_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_reg   <= POS_MAX;
            hi_reg   <= NEG_MIN;
            have_reg <= 1'b0;
        end
        else
        begin
            lo_reg   <= lo_next;
            hi_reg   <= hi_next;
            have_reg <= have_next;
        end
    end

    assign lowest    = lo_reg;
    assign highest   = hi_reg;
    assign have_scan = have_reg;

endmodule

// ----- hdl/dcr_divider.sv -----
// dcr_divider: bit-serial restoring divider, floor(dividend*511/divisor) sat. to 511.
// One quotient bit per cycle through shift registers. Depends on dcr_pkg.
module dcr_divider #(
    parameter int W = dcr_pkg::DEPTH_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [W:0]                     dividend,
    input  logic [W-1:0]                   divisor,
    output dcr_pkg::dcr_div_stat_t         stat,
    output logic [dcr_pkg::RAMP_BITS-1:0]  quotient
);
    import dcr_pkg::*;

    localparam int RB = RAMP_BITS;
    localparam int NW = W + 1 + RB;
    localparam int CW = $clog2(RB);

    localparam logic [2:0] D_IDLE  = 3'd0;
    localparam logic [2:0] D_LOAD  = 3'd1;
    localparam logic [2:0] D_CHECK = 3'd2;
    localparam logic [2:0] D_STEP  = 3'd3;
    localparam logic [2:0] D_DONE  = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    logic [NW-1:0] num_reg;
    logic [W-1:0]  dsr_reg;
    logic [W-1:0]  rem_reg;
    logic [RB-1:0] low_reg;
    logic [RB-1:0] q_reg;

    logic          over;
    logic [W:0]    trial;
    logic          ge;
    logic [W:0]    trial_sub;

    assign over      = num_reg[NW-1:RB] >= {1'b0, dsr_reg};
    assign trial     = {rem_reg, low_reg[RB-1]};
    assign ge        = trial >= {1'b0, dsr_reg};
    assign trial_sub = trial - {1'b0, dsr_reg};

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            D_IDLE:
            begin
                if (start)
                    state_next = D_LOAD;
            end
            D_LOAD:
                state_next = D_CHECK;
            D_CHECK:
            begin
                cnt_next   = '0;
                state_next = over ? D_DONE : D_STEP;
            end
            D_STEP:
            begin
                if (cnt_reg == CW'(RB - 1))
                    state_next = D_DONE;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            D_DONE:
                state_next = D_IDLE;
            default:
                state_next = D_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // numerator = dividend * 511 = (dividend << 9) - dividend
    always_ff @(posedge clk)
    begin
        if (state_reg == D_IDLE && start)
        begin
            num_reg <= NW'(dividend);
            dsr_reg <= divisor;
        end
        if (state_reg == D_LOAD)
            num_reg <= {num_reg[W:0], RB'(0)} - num_reg;
        if (state_reg == D_CHECK)
        begin
            rem_reg <= num_reg[NW-2:RB];
            low_reg <= num_reg[RB-1:0];
            q_reg   <= {RB{1'b1}};
        end
        if (state_reg == D_STEP)
        begin
            rem_reg <= ge ? trial_sub[W-1:0] : trial[W-1:0];
            low_reg <= {low_reg[RB-2:0], 1'b0};
            q_reg   <= {q_reg[RB-2:0], ge};
        end
    end

    assign stat.busy = state_reg != D_IDLE;
    assign stat.done = state_reg == D_DONE;
    assign quotient  = q_reg;

endmodule

// ----- dv/depth_colour_ramp_tb.sv -----
`timescale 1ns / 100ps
// depth_colour_ramp_tb: self-checking bench for the depth colour ramp, directed table then
// random scan/colour sets with random idling on both channels. Depends on dcr_pkg and
// depth_colour_ramp.
module depth_colour_ramp_tb;

    import dcr_pkg::*;

    localparam int                     RANDOM_ITEMS  = 700;
    localparam int                     CALM_ITEMS    = 100;
    localparam int                     HOLD_AT_ITEM  = 300;
    localparam int                     LONG_HOLD     = 400;
    localparam int                     DRAIN_CYCLES  = 40;
    localparam int                     NUM_DIRECTED  = 25;
    localparam int                     RAMP_TOP      = 511;
    localparam int                     CHAN_TOP      = 255;
    localparam logic signed [31:0]     DEPTH_MAX     = 32'sh7FFF_FFFF;
    localparam logic signed [31:0]     DEPTH_MIN     = 32'sh8000_0000;

    typedef struct {
        dcr_req_t r;
        bit       pinned;
        dcr_rsp_t want;
    } ramp_row_t;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_ready;
    dcr_req_t req       = '0;
    logic     rsp_valid;
    logic     rsp_ready = 1'b0;
    dcr_rsp_t rsp;

    logic signed [31:0] low_z;
    logic signed [31:0] high_z;
    bit                 seen_scan;

    dcr_rsp_t  colours_due[$];
    ramp_row_t directed_rows[NUM_DIRECTED];
    int        errors       = 0;
    int        sent         = 0;
    bit        calm         = 1'b0;
    bit        hold_off_now = 1'b0;
    bit        gappy        = 1'b1;

    depth_colour_ramp uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #6 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("depth_colour_ramp_tb: errors");
        $finish;
    end

    // updates the extremes on a scan; returns 1 with the colour on a colour request
    function automatic bit ramp_colour(input dcr_req_t r, output dcr_rsp_t o);
        longint z;
        longint span;
        longint diff;
        longint unsigned q;
        int pos;
        o = '0;
        z = longint'($signed(r.depth_value));
        if (r.req_type == REQ_SCAN)
        begin
            if (r.first_item)
            begin
                low_z  = DEPTH_MAX;
                high_z = DEPTH_MIN;
            end
            if (z < longint'(low_z))
                low_z = r.depth_value;
            if (z > longint'(high_z))
                high_z = r.depth_value;
            seen_scan = 1'b1;
            return 1'b0;
        end
        if (!seen_scan)
        begin
            o.no_data = 1'b1;
            return 1'b1;
        end
        span = longint'(high_z) - longint'(low_z);
        pos  = 0;
        if (span <= 0)
            o.flat_range = 1'b1;
        else
        begin
            diff = longint'(high_z) - z;
            if (diff > 0)
            begin
                q   = longint'(diff * RAMP_TOP) / span;
                pos = (q > RAMP_TOP) ? RAMP_TOP : int'(q);
            end
        end
        o.ramp_position = 9'(pos);
        if (pos <= CHAN_TOP)
        begin
            o.green = 8'(pos);
            o.blue  = 8'(CHAN_TOP - pos);
        end
        else
        begin
            o.red   = 8'(pos - (CHAN_TOP + 1));
            o.green = 8'(RAMP_TOP - pos);
        end
        return 1'b1;
    endfunction

    function automatic ramp_row_t row(input logic kind, input logic first,
                                      input logic signed [31:0] z, input bit pin,
                                      input int r, input int g, input int b,
                                      input int pos, input bit flat, input bit nd);
        ramp_row_t t;
        t.r.req_type         = kind;
        t.r.first_item       = first;
        t.r.depth_value      = z;
        t.pinned             = pin;
        t.want.red           = 8'(r);
        t.want.green         = 8'(g);
        t.want.blue          = 8'(b);
        t.want.ramp_position = 9'(pos);
        t.want.flat_range    = flat;
        t.want.no_data       = nd;
        return t;
    endfunction

    task automatic issue(input dcr_req_t item, input bit pinned, input dcr_rsp_t pinned_want);
        dcr_rsp_t guess;
        bit       makes;
        if ($urandom_range(0, 63) == 0)
            gappy = !gappy;
        if (!calm && gappy && $urandom_range(0, 5) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do
            @(posedge clk);
        while (!req_ready);
        makes = ramp_colour(item, guess);
        if (makes)
            colours_due.push_back(pinned ? pinned_want : guess);
    endtask

    task automatic issue_random(input logic kind, input logic first, input logic [31:0] z);
        dcr_req_t item;
        item.req_type    = kind;
        item.first_item  = first;
        item.depth_value = z;
        issue(item, 1'b0, '0);
        sent++;
        if (sent == HOLD_AT_ITEM)
            hold_off_now = 1'b1;
        if (sent >= RANDOM_ITEMS - CALM_ITEMS)
            calm = 1'b1;
    endtask

    // colour depth around the current extremes, a margin past each end
    function automatic logic [31:0] near_depth();
        longint span;
        longint margin;
        longint lo;
        longint unsigned offset;
        longint z;
        if (!seen_scan)
            return $urandom;
        case ($urandom_range(0, 7))
            0: return low_z;
            1: return high_z;
            default:
            begin
                span   = longint'(high_z) - longint'(low_z);
                margin = span / 4 + 1;
                lo     = longint'(low_z) - margin;
                offset = {$urandom, $urandom};
                z      = lo + longint'(offset % longint'(span + 2 * margin + 1));
                if (z > longint'(DEPTH_MAX))
                    z = DEPTH_MAX;
                if (z < longint'(DEPTH_MIN))
                    z = DEPTH_MIN;
                return z[31:0];
            end
        endcase
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin
        dcr_rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (colours_due.size() == 0)
            begin
                $display("%0t ns: unexpected result, expected none, actual %p", $time, rsp);
                errors++;
            end
            else
            begin
                want = colours_due.pop_front();
                check_field("red", want.red, rsp.red);
                check_field("green", want.green, rsp.green);
                check_field("blue", want.blue, rsp.blue);
                check_field("ramp_position", want.ramp_position, rsp.ramp_position);
                check_field("flat_range", want.flat_range, rsp.flat_range);
                check_field("no_data", want.no_data, rsp.no_data);
            end
        end
    end

    initial
    begin
        bit busy_phase;
        busy_phase = 1'b1;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 63) == 0)
                busy_phase = !busy_phase;
            if (hold_off_now)
            begin
                hold_off_now = 1'b0;
                rsp_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (!calm && busy_phase && $urandom_range(0, 4) == 0)
            begin
                rsp_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            @(posedge clk);
        end
    end

    initial
    begin
        logic [31:0] base;
        int          shift;
        int          n_scan;
        int          n_colour;
        low_z     = DEPTH_MAX;
        high_z    = DEPTH_MIN;
        seen_scan = 1'b0;

        directed_rows = '{
            row(REQ_COLOR, 1'b0, 32'sd0,          1'b1, 0,   0, 0,   0,   1'b0, 1'b1),
            row(REQ_COLOR, 1'b1, DEPTH_MAX,       1'b1, 0,   0, 0,   0,   1'b0, 1'b1),
            row(REQ_SCAN,  1'b1, 32'sh0001_0000,  1'b0, 0,   0, 0,   0,   1'b0, 1'b0),
            row(REQ_COLOR, 1'b0, 32'sh0001_0000,  1'b1, 0,   0, 255, 0,   1'b1, 1'b0),
            row(REQ_COLOR, 1'b0, -32'sh0001_0000, 1'b1, 0,   0, 255, 0,   1'b1, 1'b0),
            row(REQ_SCAN,  1'b0, DEPTH_MIN,       1'b0, 0,   0, 0,   0,   1'b0, 1'b0),
            row(REQ_SCAN,  1'b0, DEPTH_MAX,       1'b0, 0,   0, 0,   0,   1'b0, 1'b0),
            row(REQ_COLOR, 1'b0, DEPTH_MAX,       1'b1, 0,   0, 255, 0,   1'b0, 1'b0),
            row(REQ_COLOR, 1'b0, DEPTH_MIN,       1'b1, 255, 0, 0,   511, 1'b0, 1'b0),
            row(REQ_COLOR, 1'b0, 32'sd0,          1'b0, 0,   0, 0,   0,   1'b0, 1'b0),
            row(REQ_SCAN,  1'b1, 32'sd100,        1'b0, 0,   0, 0,   0,   1'b0, 1'b0),
            row(REQ_SCAN,  1'b0, -32'sd100,       1'b0, 0,   0, 0,   0,   1'b0, 1'b0),
            row(REQ_COLOR, 1'b0, 32'sd200,        1'b1, 0,   0, 255, 0,   1'b0, 1'b0),
            row(REQ_COLOR, 1'b0, -32'sd300,       1'b1, 255, 0, 0,   511, 1'b0, 1'b0),
            row(REQ_COLOR, 1'b0, 32'sd0,          1'b0, 0,   0, 0,   0,   1'b0, 1'b0),
            row(REQ_COLOR, 1'b0, -32'sd1,         1'b0, 0,   0, 0,   0,   1'b0, 1'b0),
            row(REQ_COLOR, 1'b1, 32'sd50,         1'b0, 0,   0, 0,   0,   1'b0, 1'b0),
            row(REQ_COLOR, 1'b0, -32'sd100,       1'b1, 255, 0, 0,   511, 1'b0, 1'b0),
            row(REQ_COLOR, 1'b0, 32'sd100,        1'b1, 0,   0, 255, 0,   1'b0, 1'b0),
            row(REQ_SCAN,  1'b1, DEPTH_MIN,       1'b0, 0,   0, 0,   0,   1'b0, 1'b0),
            row(REQ_COLOR, 1'b0, DEPTH_MAX,       1'b1, 0,   0, 255, 0,   1'b1, 1'b0),
            row(REQ_SCAN,  1'b1, DEPTH_MAX,       1'b0, 0,   0, 0,   0,   1'b0, 1'b0),
            row(REQ_COLOR, 1'b0, DEPTH_MIN,       1'b1, 0,   0, 255, 0,   1'b1, 1'b0),
            row(REQ_SCAN,  1'b0, -32'sd1,         1'b0, 0,   0, 0,   0,   1'b0, 1'b0),
            row(REQ_COLOR, 1'b0, DEPTH_MIN,       1'b0, 0,   0, 0,   0,   1'b0, 1'b0)
        };

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            issue(directed_rows[i].r, directed_rows[i].pinned, directed_rows[i].want);

        // mostly well-formed sets: fresh scan pass, then colours near the range
        while (sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                n_scan = $urandom_range(1, 6);
                shift  = $urandom_range(0, 31);
                base   = $urandom;
                for (int i = 0; i < n_scan; i++)
                    issue_random(REQ_SCAN, (i == 0) || ($urandom_range(0, 15) == 0),
                                 base + ($urandom >> shift) - ($urandom >> shift));
                n_colour = $urandom_range(1, 8);
                for (int i = 0; i < n_colour; i++)
                    issue_random(REQ_COLOR, 1'($urandom_range(0, 1)), near_depth());
            end
            else
                issue_random(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom);
        end

        req_valid <= 1'b0;
        while (colours_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("depth_colour_ramp_tb: clean");
        else
            $display("depth_colour_ramp_tb: errors");
        $finish;
    end

endmodule

// ----- depth_colour_ramp.f -----
hdl/dcr_pkg.sv
hdl/dcr_extremes.sv
hdl/dcr_divider.sv
hdl/depth_colour_ramp.sv
dv/depth_colour_ramp_tb.sv
